@@ sv/hev_pkg.sv @@
// ----------------------------------------------------------------------------
// hev_pkg
// Shared types and codes for the hunk executable validator.
// ----------------------------------------------------------------------------
`default_nettype none

package hev_pkg;

  // Verdict codes; the sticky error register uses the same encoding.
  localparam logic [1:0] VERDICT_VALID     = 2'd0;
  localparam logic [1:0] VERDICT_NOTEXEC   = 2'd1;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd2;

  // Parser status after the current word, before any end-of-file restart.
  typedef struct packed {
    logic [1:0] err;       // sticky error code
    logic       at_magic;  // magic word still expected
    logic       at_done;   // all hunks closed
    logic       saw_sec;   // code, data or BSS section seen
  } hev_status_t;

endpackage

`default_nettype wire

@@ sv/hev_parser.sv @@
// ----------------------------------------------------------------------------
// hev_parser
// Word-level parser state machine: header, span check, hunk walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hev_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               word_en_i,
  input  wire logic [31:0]        word_i,
  input  wire logic               restart_i,
  output hev_pkg::hev_status_t    status_o
);

  localparam logic [4:0] PH_MAGIC    = 5'd0;
  localparam logic [4:0] PH_NAME_LEN = 5'd1;
  localparam logic [4:0] PH_NAME_SKP = 5'd2;
  localparam logic [4:0] PH_TSIZE    = 5'd3;
  localparam logic [4:0] PH_FIRST    = 5'd4;
  localparam logic [4:0] PH_LAST     = 5'd5;
  localparam logic [4:0] PH_SIZES    = 5'd6;
  localparam logic [4:0] PH_TYPE     = 5'd7;
  localparam logic [4:0] PH_SEC_LEN  = 5'd8;
  localparam logic [4:0] PH_DBG_LEN  = 5'd9;
  localparam logic [4:0] PH_BODY     = 5'd10;
  localparam logic [4:0] PH_BSS_LEN  = 5'd11;
  localparam logic [4:0] PH_REL_CNT  = 5'd12;
  localparam logic [4:0] PH_REL_TGT  = 5'd13;
  localparam logic [4:0] PH_REL_SKP  = 5'd14;
  localparam logic [4:0] PH_SYM_LEN  = 5'd15;
  localparam logic [4:0] PH_SYM_NAME = 5'd16;
  localparam logic [4:0] PH_SYM_VAL  = 5'd17;
  localparam logic [4:0] PH_DONE     = 5'd18;

  localparam logic [31:0] MAGIC_HEADER = 32'd1011;
  localparam logic [29:0] TYPE_CODE    = 30'd1001;
  localparam logic [29:0] TYPE_DATA    = 30'd1002;
  localparam logic [29:0] TYPE_BSS     = 30'd1003;
  localparam logic [29:0] TYPE_RELOC   = 30'd1004;
  localparam logic [29:0] TYPE_SYMBOL  = 30'd1008;
  localparam logic [29:0] TYPE_DEBUG   = 30'd1009;
  localparam logic [29:0] TYPE_END     = 30'd1010;

  logic [4:0]  phase_q, phase_d, phase_upd;
  logic [31:0] skip_q, skip_d, skip_upd;
  logic [31:0] tsize_q, tsize_d, tsize_upd;
  logic [31:0] first_q, first_d, first_upd;
  logic [31:0] hunks_q, hunks_d, hunks_upd;
  logic        saw_q, saw_d, saw_upd;
  logic [1:0]  err_q, err_d, err_upd;

  logic [29:0] type_w;
  logic [31:0] skip_dec;
  logic [31:0] hunks_dec;
  logic [32:0] span;

  assign type_w    = word_i[29:0];  // top two flag bits dropped
  assign skip_dec  = skip_q - 32'd1;
  assign hunks_dec = hunks_q - 32'd1;
  assign span      = {1'b0, word_i} - {1'b0, first_q} + 33'd1;

  always_comb begin
    phase_upd = phase_q;
    skip_upd  = skip_q;
    tsize_upd = tsize_q;
    first_upd = first_q;
    hunks_upd = hunks_q;
    saw_upd   = saw_q;
    err_upd   = err_q;
    if (word_en_i && (err_q == hev_pkg::VERDICT_VALID)) begin
      case (phase_q)
        PH_MAGIC: begin
          if (word_i != MAGIC_HEADER) err_upd = hev_pkg::VERDICT_NOTEXEC;
          else phase_upd = PH_NAME_LEN;
        end
        PH_NAME_LEN: begin
          if (word_i == 32'd0) phase_upd = PH_TSIZE;
          else begin
            skip_upd  = word_i;
            phase_upd = PH_NAME_SKP;
          end
        end
        PH_NAME_SKP: begin
          skip_upd = skip_dec;
          if (skip_dec == 32'd0) phase_upd = PH_NAME_LEN;
        end
        PH_TSIZE: begin
          tsize_upd = word_i;
          phase_upd = PH_FIRST;
        end
        PH_FIRST: begin
          first_upd = word_i;
          phase_upd = PH_LAST;
        end
        PH_LAST: begin
          if ((tsize_q == 32'd0) || (word_i < first_q) || (span != {1'b0, tsize_q})) begin
            err_upd = hev_pkg::VERDICT_MALFORMED;
          end else begin
            hunks_upd = tsize_q;
            skip_upd  = tsize_q;
            phase_upd = PH_SIZES;
          end
        end
        PH_SIZES: begin
          skip_upd = skip_dec;
          if (skip_dec == 32'd0) phase_upd = PH_TYPE;
        end
        PH_TYPE: begin
          if ((type_w == TYPE_CODE) || (type_w == TYPE_DATA)) phase_upd = PH_SEC_LEN;
          else if (type_w == TYPE_BSS) phase_upd = PH_BSS_LEN;
          else if (type_w == TYPE_RELOC) phase_upd = PH_REL_CNT;
          else if (type_w == TYPE_SYMBOL) phase_upd = PH_SYM_LEN;
          else if (type_w == TYPE_DEBUG) phase_upd = PH_DBG_LEN;
          else if (type_w == TYPE_END) begin
            hunks_upd = hunks_dec;
            phase_upd = (hunks_dec == 32'd0) ? PH_DONE : PH_TYPE;
          end else err_upd = hev_pkg::VERDICT_MALFORMED;
        end
        PH_SEC_LEN, PH_DBG_LEN: begin
          if (phase_q == PH_SEC_LEN) saw_upd = 1'b1;
          if (word_i == 32'd0) phase_upd = PH_TYPE;
          else begin
            skip_upd  = word_i;
            phase_upd = PH_BODY;
          end
        end
        PH_BODY: begin
          skip_upd = skip_dec;
          if (skip_dec == 32'd0) phase_upd = PH_TYPE;
        end
        PH_BSS_LEN: begin
          saw_upd   = 1'b1;
          phase_upd = PH_TYPE;
        end
        PH_REL_CNT: begin
          if (word_i == 32'd0) phase_upd = PH_TYPE;
          else begin
            skip_upd  = word_i;
            phase_upd = PH_REL_TGT;
          end
        end
        PH_REL_TGT: begin
          phase_upd = PH_REL_SKP;
        end
        PH_REL_SKP: begin
          skip_upd = skip_dec;
          if (skip_dec == 32'd0) phase_upd = PH_REL_CNT;
        end
        PH_SYM_LEN: begin
          if (word_i == 32'd0) phase_upd = PH_TYPE;
          else begin
            skip_upd  = word_i;
            phase_upd = PH_SYM_NAME;
          end
        end
        PH_SYM_NAME: begin
          skip_upd = skip_dec;
          if (skip_dec == 32'd0) phase_upd = PH_SYM_VAL;
        end
        PH_SYM_VAL: begin
          phase_upd = PH_SYM_LEN;
        end
        default: begin
          // extra word after the last hunk, or a dead code
          err_upd = hev_pkg::VERDICT_MALFORMED;
        end
      endcase
    end
  end

  // Drop all state at end of file so the next byte opens a new file.
  always_comb begin
    if (restart_i) begin
      phase_d = PH_MAGIC;
      skip_d  = 32'd0;
      tsize_d = 32'd0;
      first_d = 32'd0;
      hunks_d = 32'd0;
      saw_d   = 1'b0;
      err_d   = hev_pkg::VERDICT_VALID;
    end else begin
      phase_d = phase_upd;
      skip_d  = skip_upd;
      tsize_d = tsize_upd;
      first_d = first_upd;
      hunks_d = hunks_upd;
      saw_d   = saw_upd;
      err_d   = err_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      skip_q  <= 32'd0;
      tsize_q <= 32'd0;
      first_q <= 32'd0;
      hunks_q <= 32'd0;
      saw_q   <= 1'b0;
      err_q   <= hev_pkg::VERDICT_VALID;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      tsize_q <= tsize_d;
      first_q <= first_d;
      hunks_q <= hunks_d;
      saw_q   <= saw_d;
      err_q   <= err_d;
    end
  end

  assign status_o.err      = err_upd;
  assign status_o.at_magic = (phase_upd == PH_MAGIC);
  assign status_o.at_done  = (phase_upd == PH_DONE);
  assign status_o.saw_sec  = saw_upd;

endmodule

`default_nettype wire

@@ sv/hunk_executable_validator.sv @@
// ----------------------------------------------------------------------------
// hunk_executable_validator
// Streaming format check of a big-endian hunk executable, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one file byte per transfer
//   in data_byte_i, with last_byte_i high on the final byte of the file.
//   Output channel (out_valid_o / out_stall_i) carries one verdict per file:
//   0 valid, 1 not an executable, 2 malformed.
//   Throughput: one byte per cycle, sustained, for any file length, as long
//   as the receiver takes each verdict before the next final byte arrives.
//   The final byte of a file waits in the input register; when it advances,
//   the verdict is loaded into the result register and out_valid_o rises.
//   The per-byte work (word assembly, one 32-bit decrement or 33-bit span
//   compare, and a phase update) sits between the input register and the
//   state/result registers.
//   Stall: the result register holds the verdict while out_stall_i is high;
//   bytes keep flowing until another final byte reaches the parser, which
//   then holds in the input register and stalls the input channel.
//   Reset: clears the pipeline and parser; the next byte starts a new file.
//   After every final byte the parser returns to that same state.
// ----------------------------------------------------------------------------
`default_nettype none

module hunk_executable_validator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      verdict_o
);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Word assembly
  logic [23:0] wbuf_q, wbuf_d;
  logic [1:0]  bphase_q, bphase_d, bphase_upd;

  // Result register
  logic       out_valid_q;
  logic [1:0] out_verdict_q;

  logic        advance;
  logic        in_xfer;
  logic        word_en;
  logic [31:0] word;
  logic        restart;
  logic [1:0]  verdict;
  hev_pkg::hev_status_t status;

  // A final byte may only advance when the result register is free to load.
  assign advance = s1_valid_q && !(s1_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Fourth byte closes a big-endian word and hands it to the parser.
  assign word    = {wbuf_q, s1_byte_q};
  assign word_en = advance && (bphase_q == 2'd3);
  assign restart = advance && s1_last_q;

  always_comb begin
    if (bphase_q == 2'd3) begin
      bphase_upd = 2'd0;
      wbuf_d     = 24'd0;
    end else begin
      bphase_upd = bphase_q + 2'd1;
      wbuf_d     = {wbuf_q[15:0], s1_byte_q};
    end
    bphase_d = bphase_upd;
    if (restart) begin
      bphase_d = 2'd0;
      wbuf_d   = 24'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbuf_q   <= 24'd0;
      bphase_q <= 2'd0;
    end else if (advance) begin
      wbuf_q   <= wbuf_d;
      bphase_q <= bphase_d;
    end
  end

  hev_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .word_en_i (word_en),
    .word_i    (word),
    .restart_i (restart),
    .status_o  (status)
  );

  // Verdict priority: sticky error, short file, partial word, open hunks,
  // then no loadable section.
  always_comb begin
    if (status.err != hev_pkg::VERDICT_VALID) verdict = status.err;
    else if (status.at_magic) verdict = hev_pkg::VERDICT_NOTEXEC;
    else if (bphase_upd != 2'd0) verdict = hev_pkg::VERDICT_MALFORMED;
    else if (!status.at_done) verdict = hev_pkg::VERDICT_MALFORMED;
    else if (!status.saw_sec) verdict = hev_pkg::VERDICT_MALFORMED;
    else verdict = hev_pkg::VERDICT_VALID;
  end

  // Load on a final byte; drop once the receiver takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (restart) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (restart) begin
      out_verdict_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hunk executable validator.
// ----------------------------------------------------------------------------
// Streams whole files into the block one byte per transfer and compares every
// verdict with a cycle-free model of the parser kept in a small scoreboard.
// A short directed set covers short files, bad magic, bad spans, unknown hunk
// types, truncation, trailing bytes, extra words and files without sections.
// Random files follow, mostly well formed with random content, the rest
// broken or plain noise. Sender and receiver idle at random, and in the last
// phase the receiver holds off long enough for the block to back up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Hunk type codes and header magic as they appear in the file.
  localparam logic [31:0] MAGIC_WORD   = 32'd1011;
  localparam logic [31:0] KIND_CODE    = 32'd1001;
  localparam logic [31:0] KIND_DATA    = 32'd1002;
  localparam logic [31:0] KIND_BSS     = 32'd1003;
  localparam logic [31:0] KIND_RELOC   = 32'd1004;
  localparam logic [31:0] KIND_SYMBOL  = 32'd1008;
  localparam logic [31:0] KIND_DEBUG   = 32'd1009;
  localparam logic [31:0] KIND_END     = 32'd1010;
  localparam logic [31:0] KIND_UNKNOWN = 32'd1005;  // unassigned type code
  localparam logic [31:0] TYPE_MASK    = 32'h3fff_ffff;

  // The sticky error shares the verdict encoding; valid doubles as no error.
  localparam logic [1:0] ERR_NONE = hev_pkg::VERDICT_VALID;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [4:0] {
    ST_MAGIC, ST_NAME_LEN, ST_NAME_SKIP, ST_TABLE_SIZE, ST_FIRST, ST_LAST,
    ST_SIZES, ST_TYPE, ST_SEC_LEN, ST_DBG_LEN, ST_BODY, ST_BSS_LEN,
    ST_REL_COUNT, ST_REL_TARGET, ST_REL_SKIP, ST_SYM_LEN, ST_SYM_NAME,
    ST_SYM_VALUE, ST_DONE
  } parse_state_e;

  // Parser model plus the queue of verdicts still owed by the block.
  class verdict_scoreboard;
    logic [1:0]   expected_verdicts[$];
    int           errors;
    logic [23:0]  partial_word;
    logic [1:0]   byte_count;
    parse_state_e phase;
    logic [31:0]  skip_count;
    logic [31:0]  decl_size;
    logic [31:0]  first_idx;
    logic [31:0]  hunks_open;
    bit           seen_section;
    logic [1:0]   sticky_err;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      partial_word = '0;
      byte_count   = '0;
      phase        = ST_MAGIC;
      skip_count   = '0;
      decl_size    = '0;
      first_idx    = '0;
      hunks_open   = '0;
      seen_section = 1'b0;
      sticky_err   = ERR_NONE;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function void parse_word(logic [31:0] w);
      logic [31:0] kind;
      logic [32:0] span;
      case (phase)
        ST_MAGIC: begin
          if (w != MAGIC_WORD) sticky_err = hev_pkg::VERDICT_NOTEXEC;
          else phase = ST_NAME_LEN;
        end
        ST_NAME_LEN: begin
          if (w == 0) phase = ST_TABLE_SIZE;
          else begin
            skip_count = w;
            phase = ST_NAME_SKIP;
          end
        end
        ST_NAME_SKIP: begin
          skip_count = skip_count - 1;
          if (skip_count == 0) phase = ST_NAME_LEN;
        end
        ST_TABLE_SIZE: begin
          decl_size = w;
          phase = ST_FIRST;
        end
        ST_FIRST: begin
          first_idx = w;
          phase = ST_LAST;
        end
        ST_LAST: begin
          // Span in 33 bits so a full 32-bit range cannot wrap to a match.
          span = {1'b0, w} - {1'b0, first_idx} + 33'd1;
          if (decl_size == 0 || w < first_idx || span != {1'b0, decl_size}) begin
            sticky_err = hev_pkg::VERDICT_MALFORMED;
          end else begin
            hunks_open = decl_size;
            skip_count = decl_size;
            phase = ST_SIZES;
          end
        end
        ST_SIZES: begin
          skip_count = skip_count - 1;
          if (skip_count == 0) phase = ST_TYPE;
        end
        ST_TYPE: begin
          kind = w & TYPE_MASK;
          if (kind == KIND_CODE || kind == KIND_DATA) phase = ST_SEC_LEN;
          else if (kind == KIND_BSS) phase = ST_BSS_LEN;
          else if (kind == KIND_RELOC) phase = ST_REL_COUNT;
          else if (kind == KIND_SYMBOL) phase = ST_SYM_LEN;
          else if (kind == KIND_DEBUG) phase = ST_DBG_LEN;
          else if (kind == KIND_END) begin
            hunks_open = hunks_open - 1;
            phase = (hunks_open == 0) ? ST_DONE : ST_TYPE;
          end else sticky_err = hev_pkg::VERDICT_MALFORMED;
        end
        ST_SEC_LEN, ST_DBG_LEN: begin
          if (phase == ST_SEC_LEN) seen_section = 1'b1;
          if (w == 0) phase = ST_TYPE;
          else begin
            skip_count = w;
            phase = ST_BODY;
          end
        end
        ST_BODY: begin
          skip_count = skip_count - 1;
          if (skip_count == 0) phase = ST_TYPE;
        end
        ST_BSS_LEN: begin
          seen_section = 1'b1;
          phase = ST_TYPE;
        end
        ST_REL_COUNT: begin
          if (w == 0) phase = ST_TYPE;
          else begin
            skip_count = w;
            phase = ST_REL_TARGET;
          end
        end
        ST_REL_TARGET: phase = ST_REL_SKIP;
        ST_REL_SKIP: begin
          skip_count = skip_count - 1;
          if (skip_count == 0) phase = ST_REL_COUNT;
        end
        ST_SYM_LEN: begin
          if (w == 0) phase = ST_TYPE;
          else begin
            skip_count = w;
            phase = ST_SYM_NAME;
          end
        end
        ST_SYM_NAME: begin
          skip_count = skip_count - 1;
          if (skip_count == 0) phase = ST_SYM_VALUE;
        end
        ST_SYM_VALUE: phase = ST_SYM_LEN;
        default: sticky_err = hev_pkg::VERDICT_MALFORMED;  // words past the last hunk end
      endcase
    endfunction

    function void accept_byte(logic [7:0] b, logic last_b);
      logic [1:0] verdict;
      if (byte_count == 2'd3) begin
        byte_count = '0;
        if (sticky_err == ERR_NONE) parse_word({partial_word, b});
        partial_word = '0;
      end else begin
        partial_word = {partial_word[15:0], b};
        byte_count = byte_count + 1;
      end
      if (!last_b) return;
      if (sticky_err != ERR_NONE) verdict = sticky_err;
      else if (phase == ST_MAGIC) verdict = hev_pkg::VERDICT_NOTEXEC;
      else if (byte_count != 0) verdict = hev_pkg::VERDICT_MALFORMED;
      else if (phase != ST_DONE) verdict = hev_pkg::VERDICT_MALFORMED;
      else if (!seen_section) verdict = hev_pkg::VERDICT_MALFORMED;
      else verdict = hev_pkg::VERDICT_VALID;
      expected_verdicts.push_back(verdict);
      restart();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_verdict(logic [1:0] got);
      logic [1:0] want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("verdict %0d arrived with none outstanding", got));
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) report($sformatf("verdict expected %0d, got %0d", want, got));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] verdict_o;

  always #1 clk_i = ~clk_i;

  hunk_executable_validator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o)
  );

  verdict_scoreboard sb;

  int   send_idle_pct = 0;   // chance the sender idles before a byte
  int   stall_pct     = 0;   // chance the receiver stalls in a cycle
  logic hold_req      = 1'b0;
  int   hold_left     = 0;
  bit   hold_used     = 1'b0;
  int   cycle_count   = 0;

  // File under construction: words first, then the byte stream that goes out.
  logic [31:0] file_words[$];
  logic [7:0]  file_bytes[$];
  int          bytes_sent = 0;
  int          files_sent = 0;

  // --------------------------------------------------------------------------
  // Monitor: note input transfers first, then check output transfers, both on
  // values sampled before this edge takes effect.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.accept_byte(data_byte_i, last_byte_i);
      if (out_valid_o && !out_stall_i) sb.check_verdict(verdict_o);
    end
  end

  // Receiver: random stalls, plus one long hold-off once requested so the
  // result register stays full and the next final byte backs up the input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", LIMIT_CYCLES);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // File builders
  // --------------------------------------------------------------------------
  function automatic void put(logic [31:0] w);
    file_words.push_back(w);
  endfunction

  // Set the two ignored top bits of a type word at random.
  function automatic logic [31:0] with_flags(logic [31:0] kind);
    logic [1:0] hi;
    hi = 2'($urandom_range(0, 3));
    return kind | {hi, 30'd0};
  endfunction

  function automatic void put_header(logic [31:0] tsize, logic [31:0] first,
                                     logic [31:0] last, int names);
    int n;
    put(MAGIC_WORD);
    repeat (names) begin
      n = $urandom_range(1, 2);
      put(n);
      repeat (n) put($urandom);
    end
    put(0);
    put(tsize);
    put(first);
    put(last);
  endfunction

  function automatic void put_sizes(int n);
    repeat (n) put($urandom);
  endfunction

  function automatic void put_section(logic [31:0] kind);
    int n;
    put(with_flags(kind));
    case (kind)
      KIND_CODE, KIND_DATA, KIND_DEBUG: begin
        n = $urandom_range(0, 3);
        put(n);
        repeat (n) put($urandom);
      end
      KIND_BSS: put($urandom);
      KIND_RELOC: begin
        repeat ($urandom_range(0, 2)) begin
          n = $urandom_range(1, 3);
          put(n);
          put($urandom);           // target hunk
          repeat (n) put($urandom);
        end
        put(0);
      end
      KIND_SYMBOL: begin
        repeat ($urandom_range(0, 2)) begin
          n = $urandom_range(1, 2);
          put(n);
          repeat (n) put($urandom);
          put($urandom);           // symbol value
        end
        put(0);
      end
      default: ;                   // unknown types carry nothing we know of
    endcase
  endfunction

  function automatic logic [31:0] pick_kind();
    int r;
    r = $urandom_range(0, 23);
    case (r % 6)
      0: return (r == 0) ? $urandom : KIND_CODE;
      1: return KIND_DATA;
      2: return KIND_BSS;
      3: return KIND_RELOC;
      4: return KIND_SYMBOL;
      default: return KIND_DEBUG;
    endcase
  endfunction

  function automatic void put_hunk(int sections);
    repeat (sections) put_section(pick_kind());
    put(with_flags(KIND_END));
  endfunction

  // Smallest well-formed program: one hunk holding a BSS section.
  function automatic void put_minimal();
    put_header(1, 0, 0, 0);
    put_sizes(1);
    put(KIND_BSS);
    put(32'hffff_ffff);
    put(KIND_END);
  endfunction

  // Append the words big-endian to the byte stream and clear them.
  function automatic void pack_bytes();
    foreach (file_words[i]) begin
      file_bytes.push_back(file_words[i][31:24]);
      file_bytes.push_back(file_words[i][23:16]);
      file_bytes.push_back(file_words[i][15:8]);
      file_bytes.push_back(file_words[i][7:0]);
    end
    file_words.delete();
  endfunction

  // Mostly well-formed programs with random content; the rest noise, bad
  // spans or damaged copies of a good program.
  function automatic void build_random_file();
    int          r;
    int          nh;
    int          keep;
    logic [31:0] first;
    logic [31:0] top_first;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
      return;
    end
    nh = $urandom_range(1, 3);
    top_first = 32'hffff_ffff - nh + 1;
    first = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
    if (first > top_first) first = top_first;
    if (r < 14) put_header(nh + $urandom_range(1, 2), first, first + nh - 1, 0);
    else put_header(nh, first, first + nh - 1, $urandom_range(0, 2));
    put_sizes(nh);
    repeat (nh) put_hunk($urandom_range(0, 3));
    if (r >= 80) begin
      case ($urandom_range(0, 3))
        0: file_words[$urandom_range(0, file_words.size() - 1)] = $urandom;
        1: put(($urandom_range(0, 1) == 0) ? $urandom : KIND_END);
        2: begin
          pack_bytes();
          keep = $urandom_range(1, file_bytes.size() - 1);
          while (file_bytes.size() > keep) void'(file_bytes.pop_back());
        end
        default: begin
          pack_bytes();
          repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
        end
      endcase
    end
    pack_bytes();
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one byte and hold it until the block takes the transfer.
  task automatic send_byte(logic [7:0] b, logic last_b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last_b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Send the pending byte stream as one file and drop it.
  task automatic send_file();
    int n;
    pack_bytes();
    n = file_bytes.size();
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
    file_bytes.delete();
    bytes_sent += n;
    files_sent++;
  endtask

  task automatic run_directed();
    // Single byte, then three bytes of the magic: never a complete word.
    file_bytes.push_back(8'hff);
    send_file();
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h03);
    send_file();
    // Magic alone: a header with nothing after it.
    put(MAGIC_WORD);
    send_file();
    // Wrong magic followed by a good one: the error must stick.
    put(~MAGIC_WORD);
    put_minimal();
    send_file();
    put_minimal();
    send_file();
    // Every section kind, type flags set, indices at the top of the range.
    put_header(2, 32'hffff_fffe, 32'hffff_ffff, 2);
    put_sizes(2);
    put_section(KIND_CODE);
    put_section(KIND_DATA);
    put_section(KIND_RELOC);
    put(with_flags(KIND_END));
    put_section(KIND_SYMBOL);
    put_section(KIND_DEBUG);
    put_section(KIND_BSS);
    put(with_flags(KIND_END));
    send_file();
    // Bad spans: empty table, last below first, full 32-bit range, mismatch.
    put_header(0, 0, 0, 0);
    put(KIND_END);
    send_file();
    put_header(1, 5, 4, 0);
    send_file();
    put_header(32'hffff_ffff, 0, 32'hffff_ffff, 0);
    send_file();
    put_header(3, 10, 11, 1);
    send_file();
    // Unknown type, then words that would otherwise be fine.
    put_header(1, 0, 0, 0);
    put_sizes(1);
    put(KIND_UNKNOWN);
    put_section(KIND_CODE);
    put(KIND_END);
    send_file();
    // Truncated before the end marker.
    put_minimal();
    void'(file_words.pop_back());
    send_file();
    // Trailing partial word.
    put_minimal();
    pack_bytes();
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hff);
    send_file();
    // Extra word after the last hunk end.
    put_minimal();
    put(KIND_END);
    send_file();
    // Only relocation and debug sections: no code, data or BSS.
    put_header(1, 7, 7, 0);
    put_sizes(1);
    put_section(KIND_RELOC);
    put_section(KIND_DEBUG);
    put(KIND_END);
    send_file();
  endtask

  task automatic run_random(int byte_goal, int file_goal);
    int b0;
    int f0;
    b0 = bytes_sent;
    f0 = files_sent;
    while (bytes_sent - b0 < byte_goal || files_sent - f0 < file_goal) begin
      build_random_file();
      send_file();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: light sender gaps, heavy receiver stalls.
    send_idle_pct = 35;
    stall_pct     = 72;
    run_directed();
    run_random(400, 4);

    // Phase two: swap the pressure.
    send_idle_pct = 72;
    stall_pct     = 35;
    run_random(400, 4);

    // Phase three: full rate both ways, opened by one long receiver hold-off
    // while the sender keeps offering bytes.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req <= 1'b1;
    run_random(400, 4);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
